[src/melody_square_tone_sequencer_defines.svh]
// Assertion macros for the melody sequencer checker.
`ifndef MELODY_SQUARE_TONE_SEQUENCER_DEFINES_SVH
`define MELODY_SQUARE_TONE_SEQUENCER_DEFINES_SVH

// Clocked assertion, quiet while reset is low
`define MSTS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Implication checked on every clock edge
`define MSTS_ASSERT_IMP(lbl, ante, cons, msg) \
  `MSTS_ASSERT(lbl, (ante) |-> (cons), msg)

// Implication whose consequent is checked in the next cycle
`define MSTS_ASSERT_NXT(lbl, ante, cons, msg) \
  `MSTS_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

[src/msts_pkg.sv]
package msts_pkg;

  localparam int NOTE_SLOTS_DEF = 1024;

  // Field widths
  localparam int OP_W    = 3;
  localparam int ADDR_W  = 10;
  localparam int PITCH_W = 16;
  localparam int DIV_W   = 8;
  localparam int POS_W   = 11;
  localparam int ELAP_W  = 21;
  localparam int SLOT_W  = 21;
  localparam int SND_W   = 20;
  localparam int HP_W    = 19;
  localparam int WIN_W   = 26;
  localparam int SUM_W   = 27;
  localparam int DVD_W   = 24;
  localparam int DVS_W   = 16;
  localparam int MS_W    = 16;
  localparam int OUT_W   = POS_W + 3;

  localparam logic [ELAP_W-1:0] ELAPSED_MAX = '1;

  // Timing constants in microsecond ticks
  localparam logic [DVD_W-1:0] HALF_SEC_US = 24'd500000;
  localparam logic [DVD_W-1:0] ONE_SEC_US  = 24'd1000000;
  localparam logic [DVD_W-1:0] SLOT_NUM    = 24'd13;
  // Divide by ten as multiply by ceil(2^27/10) and shift; exact below 2^26
  localparam logic [DVD_W-1:0] SLOT_RECIP  = 24'hCCCCCD;
  localparam int               SLOT_SHIFT  = 27;
  localparam logic [WIN_W-1:0] US_PER_MS   = 26'd1000;
  localparam logic [MS_W-1:0]  SKIP_MS_RST = 16'd2000;

  // Operations
  localparam logic [OP_W-1:0] OP_TICK      = 3'd0;
  localparam logic [OP_W-1:0] OP_LOAD      = 3'd1;
  localparam logic [OP_W-1:0] OP_START     = 3'd2;
  localparam logic [OP_W-1:0] OP_TOGGLE    = 3'd3;
  localparam logic [OP_W-1:0] OP_SKIP_FWD  = 3'd4;
  localparam logic [OP_W-1:0] OP_SKIP_BACK = 3'd5;
  localparam logic [OP_W-1:0] OP_STOP      = 3'd6;

  // Configuration register indexes
  localparam logic CFG_SONG_LEN = 1'b0;
  localparam logic CFG_SKIP_WIN = 1'b1;

  // Datapath actions
  localparam int ACT_W = 4;
  localparam logic [ACT_W-1:0] ACT_NONE   = 4'd0;
  localparam logic [ACT_W-1:0] ACT_TICK   = 4'd1;
  localparam logic [ACT_W-1:0] ACT_LOAD   = 4'd2;
  localparam logic [ACT_W-1:0] ACT_START  = 4'd3;
  localparam logic [ACT_W-1:0] ACT_TOGGLE = 4'd4;
  localparam logic [ACT_W-1:0] ACT_STOP   = 4'd5;
  localparam logic [ACT_W-1:0] ACT_SKINIT = 4'd6;
  localparam logic [ACT_W-1:0] ACT_RDPOS  = 4'd7;
  localparam logic [ACT_W-1:0] ACT_DIVP   = 4'd8;
  localparam logic [ACT_W-1:0] ACT_DIVD   = 4'd9;
  localparam logic [ACT_W-1:0] ACT_DIV10  = 4'd10;
  localparam logic [ACT_W-1:0] ACT_BEGIN  = 4'd11;
  localparam logic [ACT_W-1:0] ACT_SKSTEP = 4'd12;
  localparam logic [ACT_W-1:0] ACT_SKEND  = 4'd13;

  typedef struct packed {
    logic             latch;
    logic [ACT_W-1:0] act;
    logic             emit;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            is_skip;
    logic            need_note;
    logic            len_zero;
    logic            skip_go;
    logic            div_busy;
    logic            out_pend;
  } sts_t;

endpackage

[src/melody_square_tone_sequencer.sv]
// A tick, load, toggle or stop item passes the execute and emit states before its result is registered.
// A start or a tick that begins a note also reads the note and runs two divides in turn.
// A skip reads and divides once per note passed; a forward skip ends with a check for the song end.
// One item is worked on at a time; the next is taken once its result is handed off.
// Reset (rst_ni low, asynchronous) clears the player state; the note memory is not cleared.
module melody_square_tone_sequencer #(
  parameter int NOTE_SLOTS = msts_pkg::NOTE_SLOTS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [9:0] note_address, [25:10] pitch_hz, [33:26] length_divisor
  input  logic [39:0] s_axis_tdata_i,
  // [2:0] operation
  input  logic [2:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [0] buzzer_level, [1] is_playing, [2] note_sounding, [13:3] current_note
  output logic [15:0] m_axis_tdata_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  msts_pkg::cmd_t                 cmd;
  msts_pkg::sts_t                 sts;
  logic                           out_valid;
  logic [msts_pkg::OUT_W-1:0]     out_data;

  assign cfg_ready_o = 1'b1;

  msts_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_ready_i (m_axis_tready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  msts_dpath #(
    .NOTE_SLOTS (NOTE_SLOTS)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .operation_i      (s_axis_tuser_i),
    .note_address_i   (s_axis_tdata_i[9:0]),
    .pitch_hz_i       (s_axis_tdata_i[25:10]),
    .length_divisor_i (s_axis_tdata_i[33:26]),
    .cfg_we_i         (cfg_valid_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .out_take_i       (m_axis_tready_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .out_valid_o      (out_valid),
    .out_data_o       (out_data)
  );

  assign m_axis_tvalid_o = out_valid;
  assign m_axis_tdata_o  = {2'b00, out_data};

endmodule

[src/msts_ram.sv]
module msts_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port; read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/msts_div.sv]
module msts_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [msts_pkg::DVD_W-1:0] dividend_i,
  input  logic [msts_pkg::DVS_W-1:0] divisor_i,
  output logic                       busy_o,
  output logic [msts_pkg::DVD_W-1:0] quot_o
);

  localparam int CNT_W = $clog2(msts_pkg::DVD_W + 1);

  logic [msts_pkg::DVS_W-1:0] rem_q, rem_d, dvs_q;
  logic [msts_pkg::DVD_W-1:0] quo_q, quo_d;
  logic [CNT_W-1:0]           cnt_q, cnt_d;
  logic                       busy_q, busy_d;
  logic [msts_pkg::DVS_W:0]   trial, diff;
  logic                       fits;

  // One quotient bit per cycle, restoring
  assign trial = {rem_q, quo_q[msts_pkg::DVD_W-1]};
  assign fits  = trial >= {1'b0, dvs_q};
  assign diff  = trial - {1'b0, dvs_q};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      cnt_d  = CNT_W'(msts_pkg::DVD_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d  = fits ? diff[msts_pkg::DVS_W-1:0] : trial[msts_pkg::DVS_W-1:0];
      quo_d  = {quo_q[msts_pkg::DVD_W-2:0], fits};
      cnt_d  = cnt_q - 1'b1;
      busy_d = (cnt_q != CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
    end
  end

  // Operands need no reset
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) begin
      dvs_q <= divisor_i;
    end
  end

  assign busy_o = busy_q;
  assign quot_o = quo_q;

endmodule

[src/msts_dpath.sv]
module msts_dpath #(
  parameter int NOTE_SLOTS = msts_pkg::NOTE_SLOTS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [msts_pkg::OP_W-1:0]    operation_i,
  input  logic [msts_pkg::ADDR_W-1:0]  note_address_i,
  input  logic [msts_pkg::PITCH_W-1:0] pitch_hz_i,
  input  logic [msts_pkg::DIV_W-1:0]   length_divisor_i,
  input  logic                         cfg_we_i,
  input  logic                         cfg_index_i,
  input  logic [msts_pkg::MS_W-1:0]    cfg_data_i,
  input  logic                         out_take_i,
  input  msts_pkg::cmd_t               cmd_i,
  output msts_pkg::sts_t               sts_o,
  output logic                         out_valid_o,
  output logic [msts_pkg::OUT_W-1:0]   out_data_o
);

  localparam int AW = $clog2(NOTE_SLOTS);
  localparam int RW = msts_pkg::PITCH_W + msts_pkg::DIV_W;

  // Input item latch
  logic [msts_pkg::OP_W-1:0]    op_q;
  logic [msts_pkg::ADDR_W-1:0]  addr_q;
  logic [msts_pkg::PITCH_W-1:0] pitch_q;
  logic [msts_pkg::DIV_W-1:0]   div_q;

  // Configuration
  logic [msts_pkg::POS_W-1:0] song_len_q;
  logic [msts_pkg::MS_W-1:0]  skip_ms_q;

  // Player state
  logic [msts_pkg::POS_W-1:0]   pos_q, pos_d;
  logic                         play_q, play_d, sound_q, sound_d, lvl_q, lvl_d;
  logic [msts_pkg::PITCH_W-1:0] apitch_q, apitch_d;
  logic [msts_pkg::HP_W-1:0]    hp_q, hp_d, hp_t_q;
  logic [msts_pkg::SND_W-1:0]   snd_q, snd_d, snd_t_q;
  logic [msts_pkg::SLOT_W-1:0]  slot_q, slot_d, slot_t_q;
  logic [msts_pkg::DVD_W-1:0]   m13_q;
  logic [2*msts_pkg::DVD_W-1:0] recip;
  logic [msts_pkg::ELAP_W-1:0]  sns_q, sns_d, slt_q, slt_d, sns_inc, slt_inc;
  logic [msts_pkg::SUM_W-1:0]   sum_q, sum_d;
  logic [msts_pkg::WIN_W-1:0]   win_q, win_d;
  logic                         ok_q;
  logic                         out_valid_q;
  logic [msts_pkg::OUT_W-1:0]   out_q;

  logic [msts_pkg::POS_W-1:0]   len;
  logic [msts_pkg::POS_W:0]     next_pos;
  logic [31:0]                  pos_ext, addr_ext;
  logic                         pos_ok, addr_ok, is_fwd;
  logic [RW-1:0]                rdata;
  logic [msts_pkg::PITCH_W-1:0] rd_p;
  logic [msts_pkg::DIV_W-1:0]   rd_d, d_eff;
  logic                         div_start, div_busy;
  logic [msts_pkg::DVD_W-1:0]   dvd, quot;
  logic [msts_pkg::DVS_W-1:0]   dvs;

  // Effective song length and range checks
  assign len = ({21'd0, song_len_q} > 32'(NOTE_SLOTS)) ? msts_pkg::POS_W'(NOTE_SLOTS)
                                                       : song_len_q;
  assign pos_ext  = {21'd0, pos_q};
  assign addr_ext = {22'd0, addr_q};
  assign pos_ok   = pos_ext < 32'(NOTE_SLOTS);
  assign addr_ok  = addr_ext < 32'(NOTE_SLOTS);
  assign next_pos = {1'b0, pos_q} + 1'b1;
  assign is_fwd   = (op_q == msts_pkg::OP_SKIP_FWD);

  assign sns_inc = (sns_q == msts_pkg::ELAPSED_MAX) ? sns_q : sns_q + 1'b1;
  assign slt_inc = (slt_q == msts_pkg::ELAPSED_MAX) ? slt_q : slt_q + 1'b1;

  // Note memory: divisor in the upper bits, pitch in the lower
  msts_ram #(
    .WIDTH (RW),
    .DEPTH (NOTE_SLOTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.act == msts_pkg::ACT_LOAD && addr_ok),
    .waddr_i (addr_ext[AW-1:0]),
    .wdata_i ({div_q, pitch_q}),
    .re_i    (cmd_i.act == msts_pkg::ACT_RDPOS),
    .raddr_i (pos_ext[AW-1:0]),
    .rdata_o (rdata)
  );

  // Slots past the memory read as a rest with divisor 1
  assign rd_p  = ok_q ? rdata[msts_pkg::PITCH_W-1:0] : '0;
  assign rd_d  = ok_q ? rdata[RW-1:msts_pkg::PITCH_W] : '0;
  assign d_eff = (rd_d == '0) ? msts_pkg::DIV_W'(1) : rd_d;

  // Scale the sound length by 13/10: multiply by 13, then by the reciprocal of ten
  assign recip = {24'd0, m13_q} * {24'd0, msts_pkg::SLOT_RECIP};

  // Pick divider operands
  always_comb begin
    div_start = 1'b0;
    dvd       = msts_pkg::ONE_SEC_US;
    dvs       = {8'd0, d_eff};
    case (cmd_i.act)
      msts_pkg::ACT_DIVP: begin
        div_start = 1'b1;
        dvd       = msts_pkg::HALF_SEC_US;
        dvs       = (rd_p == '0) ? msts_pkg::DVS_W'(1) : rd_p;
      end
      msts_pkg::ACT_DIVD: begin
        div_start = 1'b1;
      end
      default: begin
      end
    endcase
  end

  msts_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dvd),
    .divisor_i  (dvs),
    .busy_o     (div_busy),
    .quot_o     (quot)
  );

  // Player state update
  always_comb begin
    pos_d    = pos_q;
    play_d   = play_q;
    sound_d  = sound_q;
    lvl_d    = lvl_q;
    apitch_d = apitch_q;
    hp_d     = hp_q;
    snd_d    = snd_q;
    slot_d   = slot_q;
    sns_d    = sns_q;
    slt_d    = slt_q;
    sum_d    = sum_q;
    win_d    = win_q;
    case (cmd_i.act)
      msts_pkg::ACT_TICK: begin
        sns_d = sns_inc;
        slt_d = slt_inc;
        if (play_q) begin
          if (sns_inc >= slot_q) begin
            if (next_pos >= {1'b0, len}) begin
              pos_d  = len;
              play_d = 1'b0;
              lvl_d  = 1'b0;
            end else begin
              pos_d = next_pos[msts_pkg::POS_W-1:0];
            end
          end else if (sns_inc >= {1'b0, snd_q}) begin
            sound_d = 1'b0;
            lvl_d   = 1'b0;
          end else if (apitch_q == '0) begin
            lvl_d = 1'b0;
          end else if (sound_q && slt_inc >= {2'd0, hp_q}) begin
            slt_d = '0;
            lvl_d = ~lvl_q;
          end
        end
      end
      msts_pkg::ACT_START: begin
        pos_d  = '0;
        play_d = (len != '0);
        if (len == '0) begin
          sound_d = 1'b0;
          lvl_d   = 1'b0;
        end
      end
      msts_pkg::ACT_TOGGLE: begin
        play_d = ~play_q;
      end
      msts_pkg::ACT_STOP: begin
        play_d  = 1'b0;
        sound_d = 1'b0;
        lvl_d   = 1'b0;
      end
      msts_pkg::ACT_SKINIT: begin
        sum_d = '0;
        win_d = {10'd0, skip_ms_q} * msts_pkg::US_PER_MS;
      end
      msts_pkg::ACT_BEGIN: begin
        apitch_d = rd_p;
        hp_d     = hp_t_q;
        snd_d    = snd_t_q;
        slot_d   = slot_t_q;
        sns_d    = '0;
        slt_d    = '0;
        lvl_d    = 1'b0;
        sound_d  = 1'b1;
      end
      msts_pkg::ACT_SKSTEP: begin
        sum_d = sum_q + {6'd0, slot_t_q};
        pos_d = is_fwd ? pos_q + 1'b1 : pos_q - 1'b1;
      end
      msts_pkg::ACT_SKEND: begin
        if (pos_q >= len) begin
          play_d = 1'b0;
          lvl_d  = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // Control state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      play_q      <= 1'b0;
      sound_q     <= 1'b0;
      lvl_q       <= 1'b0;
      apitch_q    <= '0;
      hp_q        <= '0;
      snd_q       <= '0;
      slot_q      <= '0;
      sns_q       <= '0;
      slt_q       <= '0;
      song_len_q  <= '0;
      skip_ms_q   <= msts_pkg::SKIP_MS_RST;
      out_valid_q <= 1'b0;
    end else begin
      pos_q    <= pos_d;
      play_q   <= play_d;
      sound_q  <= sound_d;
      lvl_q    <= lvl_d;
      apitch_q <= apitch_d;
      hp_q     <= hp_d;
      snd_q    <= snd_d;
      slot_q   <= slot_d;
      sns_q    <= sns_d;
      slt_q    <= slt_d;
      if (cfg_we_i) begin
        if (cfg_index_i == msts_pkg::CFG_SONG_LEN) begin
          song_len_q <= cfg_data_i[msts_pkg::POS_W-1:0];
        end else begin
          skip_ms_q <= cfg_data_i;
        end
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_take_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload and scratch registers
  always_ff @(posedge clk_i) begin
    sum_q    <= sum_d;
    win_q    <= win_d;
    slot_t_q <= recip[msts_pkg::SLOT_SHIFT +: msts_pkg::SLOT_W];
    if (cmd_i.latch) begin
      op_q    <= operation_i;
      addr_q  <= note_address_i;
      pitch_q <= pitch_hz_i;
      div_q   <= length_divisor_i;
    end
    if (cmd_i.act == msts_pkg::ACT_RDPOS) begin
      ok_q <= pos_ok;
    end
    if (cmd_i.act == msts_pkg::ACT_DIVD) begin
      hp_t_q <= (rd_p == '0) ? '0 : quot[msts_pkg::HP_W-1:0];
    end
    if (cmd_i.act == msts_pkg::ACT_DIV10) begin
      snd_t_q <= quot[msts_pkg::SND_W-1:0];
      m13_q   <= {4'd0, quot[msts_pkg::SND_W-1:0]} * msts_pkg::SLOT_NUM;
    end
    if (cmd_i.emit) begin
      out_q <= {pos_q, sound_q, play_q, lvl_q};
    end
  end

  assign sts_o.op        = op_q;
  assign sts_o.is_skip   = (op_q == msts_pkg::OP_SKIP_FWD) || (op_q == msts_pkg::OP_SKIP_BACK);
  assign sts_o.need_note = play_q && (sns_inc >= slot_q) && (next_pos < {1'b0, len});
  assign sts_o.len_zero  = (len == '0);
  assign sts_o.skip_go   = (sum_q < {1'b0, win_q}) && (is_fwd ? (pos_q < len) : (pos_q != '0));
  assign sts_o.div_busy  = div_busy;
  assign sts_o.out_pend  = out_valid_q;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[src/msts_ctrl.sv]
module msts_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic           out_ready_i,
  input  msts_pkg::sts_t sts_i,
  output msts_pkg::cmd_t cmd_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_EXEC  = 4'd1;
  localparam logic [3:0] S_RD    = 4'd2;
  localparam logic [3:0] S_DIV1  = 4'd3;
  localparam logic [3:0] S_W1    = 4'd4;
  localparam logic [3:0] S_DIV2  = 4'd5;
  localparam logic [3:0] S_W2    = 4'd6;
  localparam logic [3:0] S_DIV3  = 4'd7;
  localparam logic [3:0] S_W3    = 4'd8;
  localparam logic [3:0] S_FIN   = 4'd9;
  localparam logic [3:0] S_CHK   = 4'd10;
  localparam logic [3:0] S_SKEND = 4'd11;
  localparam logic [3:0] S_EMIT  = 4'd12;

  logic [3:0] state_q, state_d;
  logic       ready;

  // Take an item once the result register is free or being drained
  assign ready      = (state_q == S_IDLE) && (!sts_i.out_pend || out_ready_i);
  assign in_ready_o = ready;

  always_comb begin
    state_d     = state_q;
    cmd_o.latch = 1'b0;
    cmd_o.act   = msts_pkg::ACT_NONE;
    cmd_o.emit  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i && ready) begin
          cmd_o.latch = 1'b1;
          state_d     = S_EXEC;
        end
      end
      // Dispatch on the operation
      S_EXEC: begin
        state_d = S_EMIT;
        case (sts_i.op)
          msts_pkg::OP_TICK: begin
            cmd_o.act = msts_pkg::ACT_TICK;
            if (sts_i.need_note) state_d = S_RD;
          end
          msts_pkg::OP_LOAD:   cmd_o.act = msts_pkg::ACT_LOAD;
          msts_pkg::OP_START: begin
            cmd_o.act = msts_pkg::ACT_START;
            if (!sts_i.len_zero) state_d = S_RD;
          end
          msts_pkg::OP_TOGGLE: cmd_o.act = msts_pkg::ACT_TOGGLE;
          msts_pkg::OP_STOP:   cmd_o.act = msts_pkg::ACT_STOP;
          msts_pkg::OP_SKIP_FWD, msts_pkg::OP_SKIP_BACK: begin
            cmd_o.act = msts_pkg::ACT_SKINIT;
            state_d   = S_CHK;
          end
          default: begin
          end
        endcase
      end
      // Skip loop test
      S_CHK: begin
        if (sts_i.skip_go) begin
          state_d = S_RD;
        end else if (sts_i.op == msts_pkg::OP_SKIP_FWD) begin
          state_d = S_SKEND;
        end else begin
          state_d = S_EMIT;
        end
      end
      S_RD: begin
        cmd_o.act = msts_pkg::ACT_RDPOS;
        state_d   = S_DIV1;
      end
      S_DIV1: begin
        cmd_o.act = sts_i.is_skip ? msts_pkg::ACT_DIVD : msts_pkg::ACT_DIVP;
        state_d   = S_W1;
      end
      S_W1: begin
        if (!sts_i.div_busy) state_d = sts_i.is_skip ? S_DIV3 : S_DIV2;
      end
      S_DIV2: begin
        cmd_o.act = msts_pkg::ACT_DIVD;
        state_d   = S_W2;
      end
      S_W2: begin
        if (!sts_i.div_busy) state_d = S_DIV3;
      end
      S_DIV3: begin
        cmd_o.act = msts_pkg::ACT_DIV10;
        state_d   = S_W3;
      end
      S_W3: begin
        if (!sts_i.div_busy) state_d = S_FIN;
      end
      S_FIN: begin
        cmd_o.act = sts_i.is_skip ? msts_pkg::ACT_SKSTEP : msts_pkg::ACT_BEGIN;
        state_d   = sts_i.is_skip ? S_CHK : S_EMIT;
      end
      S_SKEND: begin
        cmd_o.act = msts_pkg::ACT_SKEND;
        state_d   = S_EMIT;
      end
      S_EMIT: begin
        cmd_o.emit = 1'b1;
        state_d    = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[src/msts_checker.sv]
`include "melody_square_tone_sequencer_defines.svh"

module msts_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [15:0] m_axis_tdata_o
);

  // A stalled item holds its payload
  `MSTS_ASSERT_NXT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o), "result changed while stalled")

  // No new item while a result waits
  `MSTS_ASSERT_IMP(a_no_take, m_axis_tvalid_o && !m_axis_tready_i, !s_axis_tready_o, "item taken while result pending")

  // A result never appears the cycle after an item is taken
  `MSTS_ASSERT_NXT(a_min_lat, s_axis_tvalid_i && s_axis_tready_o, !m_axis_tvalid_o, "result too early")

  // The buzzer is high only while the note sounds
  `MSTS_ASSERT_IMP(a_lvl_snd, m_axis_tvalid_o && m_axis_tdata_o[0], m_axis_tdata_o[2], "buzzer high while silent")

endmodule

bind melody_square_tone_sequencer msts_checker u_msts_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

[dv/melody_square_tone_sequencer_checker.sv]
module melody_square_tone_sequencer_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  // [9:0] note_address, [25:10] pitch_hz, [33:26] length_divisor
  input  logic [39:0] s_axis_tdata_i,
  // [2:0] operation
  input  logic [2:0]  s_axis_tuser_i,
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  // [0] buzzer_level, [1] is_playing, [2] note_sounding, [13:3] current_note
  input  logic [15:0] m_axis_tdata_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import msts_pkg::*;

  localparam int SLOTS = NOTE_SLOTS_DEF;
  localparam int unsigned SAT_MAX = 32'h1F_FFFF;

  typedef struct packed {
    logic [POS_W-1:0] note;
    logic             sounding;
    logic             playing;
    logic             level;
  } player_out_t;

  logic [PITCH_W-1:0] pitch_mem [SLOTS];
  logic [DIV_W-1:0]   div_mem   [SLOTS];

  int unsigned note_pos, level, cur_pitch, half_ticks, sound_len, slot_len;
  int unsigned since_start, since_toggle, song_len, skip_ms;
  bit          playing, sounding;
  player_out_t player_q [$];

  function automatic int unsigned eff_len();
    return (song_len > SLOTS) ? SLOTS : song_len;
  endfunction

  function automatic int unsigned sound_of(int unsigned d);
    return 1000000 / ((d == 0) ? 1 : d);
  endfunction

  function automatic int unsigned slot_of(int unsigned idx);
    int unsigned d;
    d = (idx < SLOTS) ? div_mem[idx] : 0;
    return sound_of(d) * 13 / 10;
  endfunction

  task automatic begin_note(int unsigned idx);
    int unsigned p, d;
    p = 0;
    d = 0;
    if (idx < SLOTS) begin
      p = pitch_mem[idx];
      d = div_mem[idx];
    end
    cur_pitch    = p;
    half_ticks   = (p == 0) ? 0 : 500000 / p;
    sound_len    = sound_of(d);
    slot_len     = sound_len * 13 / 10;
    since_start  = 0;
    since_toggle = 0;
    level        = 0;
    sounding     = 1'b1;
  endtask

  task automatic advance_tick();
    int unsigned nxt;
    if (since_start < SAT_MAX) since_start++;
    if (since_toggle < SAT_MAX) since_toggle++;
    if (!playing) return;
    if (since_start >= slot_len) begin
      nxt = note_pos + 1;
      if (nxt >= eff_len()) begin
        note_pos = eff_len() & 11'h7FF;
        playing  = 1'b0;
        level    = 0;
        return;
      end
      note_pos = nxt & 11'h7FF;
      begin_note(note_pos);
    end else if (since_start >= sound_len) begin
      sounding = 1'b0;
      level    = 0;
      return;
    end
    if (cur_pitch == 0) begin
      level = 0;
    end else if (sounding && since_toggle >= half_ticks) begin
      since_toggle = 0;
      level ^= 1;
    end
  endtask

  // Apply one accepted item to the player copy
  task automatic apply_item(logic [2:0] op, logic [9:0] addr, logic [15:0] pitch,
                            logic [7:0] div);
    longint unsigned window, sum;
    window = longint'(skip_ms) * 1000;
    sum    = 0;
    case (op)
      OP_TICK: advance_tick();
      OP_LOAD: begin
        pitch_mem[addr] = pitch;
        div_mem[addr]   = div;
      end
      OP_START: begin
        note_pos = 0;
        if (eff_len() == 0) begin
          playing  = 1'b0;
          sounding = 1'b0;
          level    = 0;
        end else begin
          playing = 1'b1;
          begin_note(0);
        end
      end
      OP_TOGGLE: playing = !playing;
      OP_SKIP_FWD: begin
        while (sum < window && note_pos < eff_len()) begin
          sum += slot_of(note_pos);
          note_pos++;
        end
        note_pos &= 11'h7FF;
        if (note_pos >= eff_len()) begin
          playing = 1'b0;
          level   = 0;
        end
      end
      OP_SKIP_BACK: begin
        while (sum < window && note_pos > 0) begin
          sum += slot_of(note_pos);
          note_pos--;
        end
      end
      OP_STOP: begin
        playing  = 1'b0;
        sounding = 1'b0;
        level    = 0;
      end
      default: ;
    endcase
  endtask

  // Track writes, items and results; compare each result with the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin
    player_out_t want, got;
    if (!rst_ni) begin
      note_pos = 0; level = 0; cur_pitch = 0; half_ticks = 0; sound_len = 0;
      slot_len = 0; since_start = 0; since_toggle = 0; song_len = 0;
      skip_ms = 2000; playing = 1'b0; sounding = 1'b0;
      player_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CFG_SONG_LEN) song_len = cfg_data_i[10:0];
        else skip_ms = cfg_data_i;
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got = m_axis_tdata_i[13:0];
        if (player_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10) $display("unexpected result %h", got);
        end else begin
          want = player_q.pop_front();
          if (got.level !== want.level || got.playing !== want.playing ||
              got.sounding !== want.sounding || got.note !== want.note) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display("mismatch: lvl %b/%b play %b/%b snd %b/%b note %0d/%0d (exp/act)",
                       want.level, got.level, want.playing, got.playing,
                       want.sounding, got.sounding, want.note, got.note);
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        apply_item(s_axis_tuser_i, s_axis_tdata_i[9:0], s_axis_tdata_i[25:10],
                   s_axis_tdata_i[33:26]);
        want.level    = level[0];
        want.playing  = playing;
        want.sounding = sounding;
        want.note     = note_pos[10:0];
        player_q.push_back(want);
      end
      pending_o = player_q.size();
    end
  end

endmodule

[dv/melody_square_tone_sequencer_tb.sv]
module melody_square_tone_sequencer_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import msts_pkg::*;

  localparam logic [OP_W-1:0] OP_NOP = 3'd7;
  localparam int CYCLE_LIMIT = 5000000;
  localparam int LOAD_SLOTS = 64;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic [2:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [15:0] cfg_data = '0;
  int          fail_count, pending;
  int          burst_left = 0;
  int          hold_req = 0;
  int          cycles = 0;

  always #4 clk_i = ~clk_i;

  melody_square_tone_sequencer dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i(s_tvalid), .s_axis_tready_o(s_tready),
    .s_axis_tdata_i(s_tdata), .s_axis_tuser_i(s_tuser),
    .m_axis_tvalid_o(m_tvalid), .m_axis_tready_i(m_tready), .m_axis_tdata_o(m_tdata),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  melody_square_tone_sequencer_checker chk (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i(s_tvalid), .s_axis_tready_i(s_tready),
    .s_axis_tdata_i(s_tdata), .s_axis_tuser_i(s_tuser),
    .m_axis_tvalid_i(m_tvalid), .m_axis_tready_i(m_tready), .m_axis_tdata_i(m_tdata),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // Stop the run at the cycle limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Stall the result side: long hold-off on request, otherwise a changing pattern
  initial begin
    int mode, span, hold;
    mode = 0;
    span = 0;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req > 0) begin
        hold = hold_req;
        hold_req = 0;
      end
      if (span == 0) begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(16, 128);
      end
      span--;
      if (hold > 0) begin
        hold--;
        m_tready <= 1'b0;
      end else begin
        case (mode)
          0: m_tready <= 1'b1;
          1: m_tready <= ($urandom_range(0, 3) != 0);
          2: m_tready <= ($urandom_range(0, 3) == 0);
          default: m_tready <= 1'($urandom_range(0, 1));
        endcase
      end
    end
  end

  // Offer one item, in bursts separated by random gaps
  task automatic send_item(logic [2:0] op, logic [9:0] addr = '0,
                           logic [15:0] pitch = '0, logic [7:0] div = '0);
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 20);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {6'b0, div, pitch, addr};
    do @(posedge clk_i); while (!s_tready);
  endtask

  // Offer an item with random filler in the unused fields
  task automatic send_rand(logic [2:0] op);
    send_item(op, 10'($urandom), 16'($urandom), 8'($urandom));
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (pending != 0);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [15:0] pick_pitch();
    case ($urandom_range(0, 5))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(20000, 65535));
      default: return 16'($urandom);
    endcase
  endfunction

  // Mostly short notes so that note ends come within reach
  function automatic logic [7:0] pick_div();
    case ($urandom_range(0, 9))
      0: return 8'd0;
      1: return 8'd1;
      2: return 8'($urandom);
      default: return 8'($urandom_range(200, 255));
    endcase
  endfunction

  task automatic random_item();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      repeat ($urandom_range(1, 10)) send_rand(OP_TICK);
    end else if (r < 65) send_item(OP_LOAD, 10'($urandom), pick_pitch(), pick_div());
    else if (r < 73) send_rand(OP_START);
    else if (r < 81) send_rand(OP_TOGGLE);
    else if (r < 87) send_rand(OP_SKIP_FWD);
    else if (r < 93) send_rand(OP_SKIP_BACK);
    else if (r < 97) send_rand(OP_STOP);
    else send_rand(OP_NOP);
  endtask

  initial begin
    logic [15:0] lens [8];
    logic [15:0] wins [8];
    lens = '{16'd63, 16'd40, 16'd1, 16'd5, 16'd0, 16'd3, 16'd20, 16'd2};
    wins = '{16'd60000, 16'd0, 16'd3, 16'd65535, 16'd2000, 16'd10, 16'd1, 16'd7};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    // Load the low slots; song lengths stay below their count so every read hits one
    send_item(OP_LOAD, 10'd0, 16'hFFFF, 8'd255);
    send_item(OP_LOAD, 10'd1, 16'd0, 8'd255);
    send_item(OP_LOAD, 10'd2, 16'd1, 8'd255);
    for (int i = 3; i < LOAD_SLOTS - 1; i++) send_item(OP_LOAD, 10'(i), pick_pitch(), pick_div());
    send_item(OP_LOAD, 10'(LOAD_SLOTS - 1), 16'hFFFF, 8'd0);
    drain();

    // Directed: resume with no note started, then the basic commands
    write_reg(CFG_SONG_LEN, 16'd3);
    write_reg(CFG_SKIP_WIN, 16'd2000);
    send_item(OP_TOGGLE);
    send_item(OP_TICK);
    send_item(OP_TICK);
    send_item(OP_STOP);
    send_item(OP_START);
    repeat (5) send_item(OP_TICK);
    send_item(OP_TOGGLE);
    send_item(OP_TICK);
    send_item(OP_TOGGLE);
    send_item(OP_TICK);
    send_item(OP_SKIP_FWD);
    send_item(OP_SKIP_BACK);
    send_item(OP_SKIP_BACK);
    send_item(OP_NOP, 10'h3FF, 16'hFFFF, 8'hFF);
    send_item(OP_STOP);
    drain();

    // Start and skips on an empty song
    write_reg(CFG_SONG_LEN, 16'd0);
    send_item(OP_START);
    send_item(OP_SKIP_FWD);
    send_item(OP_SKIP_BACK);
    drain();

    // Play a short song, then skip back twice; hold off the result side meanwhile
    write_reg(CFG_SONG_LEN, 16'd3);
    write_reg(CFG_SKIP_WIN, 16'd1);
    send_item(OP_START);
    hold_req = 600;
    repeat (150) send_item(OP_TICK);
    send_item(OP_SKIP_BACK);
    send_item(OP_SKIP_BACK);
    drain();

    // Random phases across register settings
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(CFG_SONG_LEN, ($urandom_range(0, 2) == 0) ? 16'($urandom_range(0, LOAD_SLOTS - 1))
                                                         : lens[ph]);
      write_reg(CFG_SKIP_WIN, ($urandom_range(0, 2) == 0) ? 16'($urandom_range(0, 500))
                                                         : wins[ph]);
      if (ph == 4) hold_req = 800;
      repeat (12) random_item();
      drain();
    end

    s_tvalid <= 1'b0;
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[melody_square_tone_sequencer.f]
+incdir+src
src/msts_pkg.sv
src/msts_ram.sv
src/msts_div.sv
src/msts_dpath.sv
src/msts_ctrl.sv
src/melody_square_tone_sequencer.sv
src/msts_checker.sv
dv/melody_square_tone_sequencer_checker.sv
dv/melody_square_tone_sequencer_tb.sv
